/* rtl/rcdi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table package
// Request and result types, request and status codes, and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rcdi_pkg;

  localparam int NUM_KINDS = 3;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_GET  = 2'd1;
  localparam logic [1:0] REQ_LOAD = 2'd2;

  localparam logic [1:0] KIND_PEN    = 2'd0;
  localparam logic [1:0] KIND_BRUSH  = 2'd1;
  localparam logic [1:0] KIND_SYMBOL = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NEW     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  kind;
    logic [63:0] key;
    logic [31:0] load_count;
    logic [6:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  entry_index;
    logic [63:0] entry_key;
    logic [31:0] entry_count;
    logic [6:0]  table_fill;
  } out_item_t;

  typedef struct packed {
    logic latch;
    logic rd_scan;
    logic scan_first;
    logic rd_get;
    logic op_append;
    logic op_hit;
    logic op_get;
    logic op_inval;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       kind_ok;
    logic       get_ok;
    logic       tbl_empty;
    logic       at_end;
    logic       hit;
  } dp_sts_t;

endpackage

/* rtl/rcdi_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table datapath
// Request register, key and count memories with one read and one write port,
// per-table fill counters, scan pointer and the result register.
// ----------------------------------------------------------------------------
module rcdi_datapath #(
  parameter int ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rcdi_pkg::in_item_t in_data,
  input  rcdi_pkg::dp_cmd_t  cmd,
  output rcdi_pkg::dp_sts_t  sts,
  output rcdi_pkg::out_item_t res
);

  localparam int AW    = $clog2(ENTRIES + 1);
  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DEPTH = rcdi_pkg::NUM_KINDS * ENTRIES;
  localparam int MW    = $clog2(DEPTH);
  localparam int CW    = (AW > 7) ? AW : 7;

  logic [63:0] key_mem [DEPTH];
  logic [31:0] cnt_mem [DEPTH];

  rcdi_pkg::in_item_t  req_r;
  rcdi_pkg::out_item_t res_r, res_nxt;
  logic [AW-1:0]       fill_r [rcdi_pkg::NUM_KINDS];
  logic [AW-1:0]       fill_nxt [rcdi_pkg::NUM_KINDS];
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [IW-1:0]       rd_idx_r;
  logic [63:0]         key_q_r;
  logic [31:0]         cnt_q_r;

  logic [MW-1:0] base;
  logic [AW-1:0] fill_sel;
  logic          full;
  logic          rd_en;
  logic [IW-1:0] rd_pos;
  logic [MW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_pos;
  logic [MW-1:0] wr_addr;
  logic [31:0]   wr_cnt;
  logic [31:0]   cnt_inc;
  logic [AW-1:0] fill_inc;

  always_comb begin
    case (req_r.kind)
      rcdi_pkg::KIND_PEN: begin
        base     = '0;
        fill_sel = fill_r[0];
      end
      rcdi_pkg::KIND_BRUSH: begin
        base     = MW'(ENTRIES);
        fill_sel = fill_r[1];
      end
      rcdi_pkg::KIND_SYMBOL: begin
        base     = MW'(2 * ENTRIES);
        fill_sel = fill_r[2];
      end
      default: begin
        base     = '0;
        fill_sel = '0;
      end
    endcase
  end

  assign full     = (fill_sel == AW'(ENTRIES));
  assign fill_inc = fill_sel + AW'(1);
  assign cnt_inc  = (cnt_q_r == rcdi_pkg::COUNT_MAX) ? cnt_q_r : cnt_q_r + 32'd1;

  assign rd_en   = cmd.rd_scan || cmd.rd_get;
  assign rd_pos  = cmd.rd_get ? IW'(req_r.index - 7'd1) :
                   (cmd.scan_first ? '0 : IW'(ptr_r));
  assign rd_addr = base + MW'(rd_pos);

  assign wr_en   = cmd.op_hit || (cmd.op_append && !full);
  assign wr_pos  = cmd.op_hit ? rd_idx_r : IW'(fill_sel);
  assign wr_addr = base + MW'(wr_pos);
  assign wr_cnt  = cmd.op_hit ? cnt_inc :
                   ((req_r.req_type == rcdi_pkg::REQ_LOAD) ? req_r.load_count : 32'd1);

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.rd_scan) begin
      ptr_nxt = AW'(rd_pos) + AW'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < rcdi_pkg::NUM_KINDS; k++) begin
      fill_nxt[k] = fill_r[k];
      if (cmd.op_append && !full && (req_r.kind == 2'(k))) begin
        fill_nxt[k] = fill_inc;
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.op_append) begin
      if (full) begin
        res_nxt = '{status: rcdi_pkg::ST_FULL, entry_index: 7'd0, entry_key: 64'd0,
                    entry_count: 32'd0, table_fill: 7'(fill_sel)};
      end else begin
        res_nxt = '{status: rcdi_pkg::ST_NEW, entry_index: 7'(fill_inc),
                    entry_key: req_r.key, entry_count: wr_cnt,
                    table_fill: 7'(fill_inc)};
      end
    end else if (cmd.op_hit) begin
      res_nxt = '{status: rcdi_pkg::ST_FOUND,
                  entry_index: 7'(AW'(rd_idx_r) + AW'(1)),
                  entry_key: key_q_r, entry_count: cnt_inc,
                  table_fill: 7'(fill_sel)};
    end else if (cmd.op_get) begin
      res_nxt = '{status: rcdi_pkg::ST_FOUND, entry_index: req_r.index,
                  entry_key: key_q_r, entry_count: cnt_q_r,
                  table_fill: 7'(fill_sel)};
    end else if (cmd.op_inval) begin
      res_nxt = '{status: rcdi_pkg::ST_INVALID, entry_index: 7'd0, entry_key: 64'd0,
                  entry_count: 32'd0, table_fill: 7'(fill_sel)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= req_r.key;
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      key_q_r  <= key_mem[rd_addr];
      cnt_q_r  <= cnt_mem[rd_addr];
      rd_idx_r <= rd_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_data;
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int k = 0; k < rcdi_pkg::NUM_KINDS; k++) begin
        fill_r[k] <= '0;
      end
    end else begin
      ptr_r <= ptr_nxt;
      for (int k = 0; k < rcdi_pkg::NUM_KINDS; k++) begin
        fill_r[k] <= fill_nxt[k];
      end
    end
  end

  assign sts.req_type  = req_r.req_type;
  assign sts.kind_ok   = (req_r.kind != 2'd3);
  assign sts.get_ok    = (req_r.index != 7'd0) && (CW'(req_r.index) <= CW'(fill_sel));
  assign sts.tbl_empty = (fill_sel == '0);
  assign sts.at_end    = (ptr_r == fill_sel);
  assign sts.hit       = (key_q_r == req_r.key);

  assign res = res_r;

endmodule

/* rtl/rcdi_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intern table controller
// Sequences one request at a time through decode, table scan, lookup and
// update, and owns the result valid flag.
// ----------------------------------------------------------------------------
module rcdi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rcdi_pkg::dp_sts_t sts,
  output rcdi_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPEND,
    S_HIT,
    S_GET,
    S_INVAL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   op_any;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.kind_ok) begin
          state_nxt = S_INVAL;
        end else begin
          case (sts.req_type)
            rcdi_pkg::REQ_ADD: begin
              if (sts.tbl_empty) begin
                state_nxt = S_APPEND;
              end else begin
                cmd.rd_scan    = 1'b1;
                cmd.scan_first = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            rcdi_pkg::REQ_GET: begin
              if (sts.get_ok) begin
                cmd.rd_get = 1'b1;
                state_nxt  = S_GET;
              end else begin
                state_nxt = S_INVAL;
              end
            end
            rcdi_pkg::REQ_LOAD: begin
              state_nxt = S_APPEND;
            end
            default: begin
              state_nxt = S_INVAL;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          state_nxt = S_HIT;
        end else if (!sts.at_end) begin
          cmd.rd_scan = 1'b1;
        end else begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (out_free) begin
          cmd.op_append = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_HIT: begin
        if (out_free) begin
          cmd.op_hit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_GET: begin
        if (out_free) begin
          cmd.op_get = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_INVAL: begin
        if (out_free) begin
          cmd.op_inval = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign op_any        = cmd.op_append || cmd.op_hit || cmd.op_get || cmd.op_inval;
  assign out_valid_nxt = op_any ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.op_append, cmd.op_hit, cmd.op_get, cmd.op_inval}))
    else $error("More than one result operation in a cycle.");

  a_op_free: assert property (@(posedge clk) disable iff (!rst_n)
    op_any |-> (!out_valid_r || out_ready))
    else $error("Result written over an undelivered result.");

  a_op_valid: assert property (@(posedge clk) disable iff (!rst_n)
    op_any |=> out_valid_r)
    else $error("Result produced without raising out_valid.");

  a_scan_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.hit) |=> (state_r == S_HIT))
    else $error("Scan match did not move to the hit state.");

endmodule

/* rtl/refcounted_dedup_intern_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted deduplicating intern table
// Three tables (pen, brush, symbol) of ENTRIES keys with reference counts.
// Add searches and bumps or appends, load appends with a given count, and get
// reads an entry by its 1-based index.
// ----------------------------------------------------------------------------
// The block handles one request at a time. An add scans the selected table
// from index 1 and stops at the first match or after the last stored entry;
// the scan reads one stored key per cycle through the single read port of
// the key memory. Get, load and invalid requests do not scan. A result waits
// in an output register; the next request is accepted while it is pending.
// No clearing pass is needed after reset.
module refcounted_dedup_intern_table #(
  parameter int ENTRIES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcdi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rcdi_pkg::out_item_t out_data
);

  rcdi_pkg::dp_cmd_t cmd;
  rcdi_pkg::dp_sts_t sts;

  rcdi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rcdi_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

endmodule
